>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define FQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define FQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/fqsr_pkg.sv
// ---------------------------------------------------------------------------
// fqsr_pkg
// Types and constants shared by the search/remove queue and its cells.
// ---------------------------------------------------------------------------
package fqsr_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ACT_ENQUEUE  = 2'd0,
    ACT_DEQUEUE  = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_CONTAINS = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Broadcast to every cell; all strobes low unless a beat is accepted.
  typedef struct packed {
    logic                     enq;        // append at first free cell
    logic                     shift_all;  // dequeue: whole row moves headward
    logic                     remove;     // cells from first match onward move
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

>>> rtl/fqsr_cell.sv
// ---------------------------------------------------------------------------
// fqsr_cell
// One queue slot: holds an entry, compares it to the search value and takes
// its right neighbor's entry when the row closes a gap.
// ---------------------------------------------------------------------------
module fqsr_cell
  import fqsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_cmd_t                cmd,
  input  logic                     left_valid,  // tied high for the head cell
  input  logic                     left_hit,    // match seen nearer the head
  input  logic                     right_valid, // tied low for the last cell
  input  logic signed [DATA_W-1:0] right_data,
  output logic                     valid,
  output logic signed [DATA_W-1:0] data,
  output logic                     hit_out,
  output logic                     valid_next,
  output logic                     take
);

  logic                     match;
  logic                     shift;
  logic signed [DATA_W-1:0] data_next;

  assign match   = valid && (data == cmd.value);
  assign hit_out = left_hit || match;
  assign shift   = cmd.shift_all || (cmd.remove && hit_out);
  assign take    = cmd.enq && !valid && left_valid;

  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (shift) begin
      valid_next = right_valid;
      data_next  = right_data;
    end else if (take) begin
      valid_next = 1'b1;
      data_next  = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> rtl/fifo_queue_with_search_remove_unit.sv
// Latency: a result beat is presented the cycle after its input beat is accepted.
// Throughput: one beat per cycle while not stalled; each action is one cell-row update.
// The first-match search ripples a one-bit hit flag down the row of CAPACITY cells.
// in_ready drops only while a result beat waits with out_ready low.
// Reset (rst, synchronous, active high) empties the queue and drops any pending result;
// entry data is not cleared, since only occupied cells are ever read.
// ---------------------------------------------------------------------------
// fifo_queue_with_search_remove_unit
// Bounded FIFO of signed 32-bit values with enqueue, dequeue, remove-first-
// match and contains, built as a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_queue_with_search_remove_unit
  import fqsr_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               action,
  input  logic signed [DATA_W-1:0] value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] data_out,
  output logic                     found,
  output logic                     is_empty,
  output logic                     is_full
);

  logic      accept;
  action_t   act;
  cell_cmd_t cmd;

  // Per-cell taps of the row.
  logic [CAPACITY-1:0]             cell_valid;
  logic [CAPACITY-1:0]             cell_valid_next;
  logic [CAPACITY-1:0]             cell_hit;
  logic [CAPACITY-1:0]             cell_take;
  logic signed [DATA_W-1:0]        cell_data [CAPACITY];

  logic                     hit_end;
  status_t                  status_c;
  logic signed [DATA_W-1:0] data_c;
  logic                     found_c;

  // A waiting result blocks input only while the sink stalls.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign act      = action_t'(action);

  always_comb begin
    cmd           = '0;
    cmd.value     = value;
    cmd.enq       = accept && (act == ACT_ENQUEUE);
    cmd.shift_all = accept && (act == ACT_DEQUEUE);
    cmd.remove    = accept && (act == ACT_REMOVE);
  end

  // Cell 0 is the head. Hit flag runs head to tail, data flows tail to head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     lv;
    logic                     lh;
    logic                     rv;
    logic signed [DATA_W-1:0] rd;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lh = 1'b0;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign lh = cell_hit[i-1];
    end

    if (i == CAPACITY-1) begin : g_tail
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_inner
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end

    fqsr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left_valid (lv),
      .left_hit   (lh),
      .right_valid(rv),
      .right_data (rd),
      .valid      (cell_valid[i]),
      .data       (cell_data[i]),
      .hit_out    (cell_hit[i]),
      .valid_next (cell_valid_next[i]),
      .take       (cell_take[i])
    );
  end

  assign hit_end = cell_hit[CAPACITY-1];

  // Result of the beat being accepted, from the row before its update.
  always_comb begin
    status_c = ST_OK;
    data_c   = '0;
    found_c  = 1'b0;
    unique case (act)
      ACT_ENQUEUE: begin
        if (cell_valid[CAPACITY-1]) begin
          status_c = ST_FULL;
        end
      end
      ACT_DEQUEUE: begin
        if (!cell_valid[0]) begin
          status_c = ST_EMPTY;
        end else begin
          data_c = cell_data[0];
        end
      end
      ACT_REMOVE: begin
        found_c = hit_end;
        if (!cell_valid[0]) begin
          status_c = ST_EMPTY;
        end else if (!hit_end) begin
          status_c = ST_NOT_FOUND;
        end
      end
      ACT_CONTAINS: begin
        found_c = hit_end;
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_c;
      data_out <= data_c;
      found    <= found_c;
      is_empty <= !cell_valid_next[0];
      is_full  <= cell_valid_next[CAPACITY-1];
    end
  end

  // Occupied cells must form an unbroken run from the head.
  logic [CAPACITY-1:0] vld_inc;
  assign vld_inc = cell_valid + {{(CAPACITY-1){1'b0}}, 1'b1};

  `FQ_ASSERT(a_valid_packed, (vld_inc & cell_valid) == '0, "queue cells not packed at head")
  `FQ_ASSERT(a_single_take, $onehot0(cell_take), "enqueue written into more than one cell")
  `FQ_ASSERT_IMP(a_found_ok, out_valid && found, status == ST_OK, "found with non-ok status")
  `FQ_ASSERT_IMP(a_empty_flag, out_valid && (status == ST_EMPTY), is_empty, "empty status on nonempty queue")

endmodule
